[hdl/vsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsc_pkg: shared types and constants of the version string comparator
// Buffer geometry, function and result codes, character classes, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int PTR_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;

    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W-1:0] LEN_FULL = PTR_W'(MAX_LEN);

    // Function codes of an input beat
    localparam logic [1:0] FUNC_LOAD1 = 2'd0;
    localparam logic [1:0] FUNC_LOAD2 = 2'd1;
    localparam logic [1:0] FUNC_CMP   = 2'd2;

    // Result codes
    localparam logic signed [1:0] ORD_LT = -2'sd1;
    localparam logic signed [1:0] ORD_EQ = 2'sd0;
    localparam logic signed [1:0] ORD_GT = 2'sd1;

    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;

    typedef struct packed {
        logic load1;
        logic load2;
        logic clear;
        logic init;
        logic rd_en;
        logic sel_pq;
        logic adv_i;
        logic adv_j;
        logic adv_p;
        logic adv_q;
        logic set_pq;
    } cmd_t;

    typedef struct packed {
        logic c1_nul;
        logic c2_nul;
        logic c1_digit;
        logic c2_digit;
        logic c1_alpha;
        logic c2_alpha;
        logic c1_is0;
        logic c2_is0;
        logic ch_eq;
        logic ch_lt;
        logic i_lt_p;
        logic j_lt_q;
        logic q_eq_j;
        logic run_ne;
        logic run1_lt;
        logic seg1_gt;
        logic seg2_gt;
        logic trunc;
    } stat_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

endpackage

[hdl/vsc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsc_dp: comparator datapath
// Two character buffers, their lengths, the truncation flag, the walk
// pointers and the character classification fed back to the controller.
// ----------------------------------------------------------------------------
module vsc_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  vsc_pkg::cmd_t                  cmd,
    input  logic [vsc_pkg::CHAR_W-1:0]     char_code,
    output vsc_pkg::stat_t                 stat
);

    logic [vsc_pkg::CHAR_W-1:0] mem1 [vsc_pkg::MAX_LEN];
    logic [vsc_pkg::CHAR_W-1:0] mem2 [vsc_pkg::MAX_LEN];

    logic [vsc_pkg::PTR_W-1:0]  len1_reg, len1_next;
    logic [vsc_pkg::PTR_W-1:0]  len2_reg, len2_next;
    logic                       trunc_reg, trunc_next;
    logic [vsc_pkg::PTR_W-1:0]  i_reg, i_next;
    logic [vsc_pkg::PTR_W-1:0]  j_reg, j_next;
    logic [vsc_pkg::PTR_W-1:0]  p_reg, p_next;
    logic [vsc_pkg::PTR_W-1:0]  q_reg, q_next;

    logic [vsc_pkg::CHAR_W-1:0] rd1_reg, rd2_reg;
    logic                       v1_reg, v2_reg;
    logic [vsc_pkg::PTR_W-1:0]  ra1, ra2;
    logic [vsc_pkg::CHAR_W-1:0] c1, c2;
    logic [vsc_pkg::PTR_W-1:0]  run1, run2, seg1, seg2;

    // Buffer writes, one byte a beat, at the current fill level
    always_ff @(posedge clk)
    begin
        if (cmd.load1 && (len1_reg < vsc_pkg::LEN_FULL))
        begin
            mem1[len1_reg[vsc_pkg::ADDR_W-1:0]] <= char_code;
        end
        if (cmd.load2 && (len2_reg < vsc_pkg::LEN_FULL))
        begin
            mem2[len2_reg[vsc_pkg::ADDR_W-1:0]] <= char_code;
        end
    end

    // Registered reads; a position at or past the length reads as NUL
    assign ra1 = cmd.sel_pq ? p_reg : i_reg;
    assign ra2 = cmd.sel_pq ? q_reg : j_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd1_reg <= mem1[ra1[vsc_pkg::ADDR_W-1:0]];
            rd2_reg <= mem2[ra2[vsc_pkg::ADDR_W-1:0]];
            v1_reg  <= (ra1 < len1_reg);
            v2_reg  <= (ra2 < len2_reg);
        end
    end

    always_comb
    begin
        len1_next  = len1_reg;
        len2_next  = len2_reg;
        trunc_next = trunc_reg;
        if (cmd.load1)
        begin
            if (len1_reg < vsc_pkg::LEN_FULL)
                len1_next = len1_reg + vsc_pkg::PTR_ONE;
            else
                trunc_next = 1'b1;
        end
        if (cmd.load2)
        begin
            if (len2_reg < vsc_pkg::LEN_FULL)
                len2_next = len2_reg + vsc_pkg::PTR_ONE;
            else
                trunc_next = 1'b1;
        end
        if (cmd.clear)
        begin
            len1_next  = '0;
            len2_next  = '0;
            trunc_next = 1'b0;
        end
    end

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        p_next = p_reg;
        q_next = q_reg;
        if (cmd.adv_i)
            i_next = i_reg + vsc_pkg::PTR_ONE;
        if (cmd.adv_j)
            j_next = j_reg + vsc_pkg::PTR_ONE;
        if (cmd.adv_p)
            p_next = p_reg + vsc_pkg::PTR_ONE;
        if (cmd.adv_q)
            q_next = q_reg + vsc_pkg::PTR_ONE;
        if (cmd.set_pq)
        begin
            p_next = i_reg;
            q_next = j_reg;
        end
        if (cmd.init)
        begin
            i_next = '0;
            j_next = '0;
            p_next = '0;
            q_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg  <= '0;
            len2_reg  <= '0;
            trunc_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
        end
        else
        begin
            len1_reg  <= len1_next;
            len2_reg  <= len2_next;
            trunc_reg <= trunc_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
        end
    end

    assign c1 = v1_reg ? rd1_reg : vsc_pkg::CH_NUL;
    assign c2 = v2_reg ? rd2_reg : vsc_pkg::CH_NUL;

    // Separator run lengths and segment lengths after zero stripping
    assign run1 = i_reg - p_reg;
    assign run2 = j_reg - q_reg;
    assign seg1 = p_reg - i_reg;
    assign seg2 = q_reg - j_reg;

    always_comb
    begin
        stat.c1_nul   = (c1 == vsc_pkg::CH_NUL);
        stat.c2_nul   = (c2 == vsc_pkg::CH_NUL);
        stat.c1_digit = vsc_pkg::is_digit(c1);
        stat.c2_digit = vsc_pkg::is_digit(c2);
        stat.c1_alpha = vsc_pkg::is_alpha(c1);
        stat.c2_alpha = vsc_pkg::is_alpha(c2);
        stat.c1_is0   = (c1 == vsc_pkg::CH_ZERO);
        stat.c2_is0   = (c2 == vsc_pkg::CH_ZERO);
        stat.ch_eq    = (c1 == c2);
        stat.ch_lt    = (c1 < c2);
        stat.i_lt_p   = (i_reg < p_reg);
        stat.j_lt_q   = (j_reg < q_reg);
        stat.q_eq_j   = (q_reg == j_reg);
        stat.run_ne   = (run1 != run2);
        stat.run1_lt  = (run1 < run2);
        stat.seg1_gt  = (seg1 > seg2);
        stat.seg2_gt  = (seg2 > seg1);
        stat.trunc    = trunc_reg;
    end

endmodule

[hdl/vsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsc_ctrl: comparator sequencer
// Takes load and compare beats, then steps the segment walk: a step either issues
// one buffer read and decides on the next cycle, or decides on characters already held.
// ----------------------------------------------------------------------------
module vsc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             func,
    input  vsc_pkg::stat_t         stat,
    input  logic                   out_free,
    output logic                   busy,
    output logic                   done,
    output logic signed [1:0]      result,
    output vsc_pkg::cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EQ   = 3'd1;
    localparam logic [2:0] ST_TOP  = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;
    localparam logic [2:0] ST_ZERO = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              phase_reg, phase_next;
    logic              isnum_reg, isnum_next;
    logic signed [1:0] result_reg, result_next;

    logic              skip1, skip2, match1, match2, zero1, zero2;
    logic signed [1:0] tail_ord;

    assign skip1  = !stat.c1_nul && !stat.c1_digit && !stat.c1_alpha;
    assign skip2  = !stat.c2_nul && !stat.c2_digit && !stat.c2_alpha;
    assign match1 = isnum_reg ? stat.c1_digit : stat.c1_alpha;
    assign match2 = isnum_reg ? stat.c2_digit : stat.c2_alpha;
    assign zero1  = stat.i_lt_p && stat.c1_is0;
    assign zero2  = stat.j_lt_q && stat.c2_is0;

    // Outcome once either string has run out of segments
    always_comb
    begin
        if (stat.c1_nul && stat.c2_nul)
            tail_ord = vsc_pkg::ORD_EQ;
        else if ((stat.c1_nul && !stat.c2_alpha) || stat.c1_alpha)
            tail_ord = vsc_pkg::ORD_LT;
        else
            tail_ord = vsc_pkg::ORD_GT;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        isnum_next  = isnum_reg;
        result_next = result_reg;
        cmd         = '0;

        if ((state_reg != ST_IDLE) && (state_reg != ST_DONE) && !phase_reg)
        begin
            // read phase: fetch both characters at the current pointers
            cmd.rd_en  = 1'b1;
            cmd.sel_pq = (state_reg == ST_RUN);
            phase_next = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (func)
                            vsc_pkg::FUNC_LOAD1: cmd.load1 = 1'b1;
                            vsc_pkg::FUNC_LOAD2: cmd.load2 = 1'b1;
                            vsc_pkg::FUNC_CMP:
                            begin
                                cmd.init   = 1'b1;
                                state_next = ST_EQ;
                                phase_next = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EQ:
                begin
                    phase_next = 1'b0;
                    if (!stat.ch_eq)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_TOP;
                    end
                    else if (stat.c1_nul)
                    begin
                        result_next = vsc_pkg::ORD_EQ;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.adv_i = 1'b1;
                        cmd.adv_j = 1'b1;
                    end
                end
                ST_TOP:
                begin
                    if (stat.c1_nul || stat.c2_nul)
                    begin
                        result_next = tail_ord;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    if (skip1 || skip2)
                    begin
                        cmd.adv_i  = skip1;
                        cmd.adv_j  = skip2;
                        phase_next = 1'b0;
                    end
                    else if (stat.c1_nul || stat.c2_nul)
                    begin
                        result_next = tail_ord;
                        state_next  = ST_DONE;
                    end
                    else if (stat.run_ne)
                    begin
                        result_next = stat.run1_lt ? vsc_pkg::ORD_LT : vsc_pkg::ORD_GT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // segment starts here; characters at p and q are already held
                        cmd.set_pq = 1'b1;
                        isnum_next = stat.c1_digit;
                        state_next = ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (match1 || match2)
                    begin
                        cmd.adv_p  = match1;
                        cmd.adv_q  = match2;
                        phase_next = 1'b0;
                    end
                    else if (stat.q_eq_j)
                    begin
                        result_next = isnum_reg ? vsc_pkg::ORD_GT : vsc_pkg::ORD_LT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = isnum_reg ? ST_ZERO : ST_CMP;
                        phase_next = 1'b0;
                    end
                end
                ST_ZERO:
                begin
                    if (zero1 || zero2)
                    begin
                        cmd.adv_i  = zero1;
                        cmd.adv_j  = zero2;
                        phase_next = 1'b0;
                    end
                    else if (stat.seg1_gt)
                    begin
                        result_next = vsc_pkg::ORD_GT;
                        state_next  = ST_DONE;
                    end
                    else if (stat.seg2_gt)
                    begin
                        result_next = vsc_pkg::ORD_LT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (stat.i_lt_p && stat.j_lt_q)
                    begin
                        if (!stat.ch_eq)
                        begin
                            result_next = stat.ch_lt ? vsc_pkg::ORD_LT : vsc_pkg::ORD_GT;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.adv_i  = 1'b1;
                            cmd.adv_j  = 1'b1;
                            phase_next = 1'b0;
                        end
                    end
                    else if (stat.i_lt_p)
                    begin
                        result_next = vsc_pkg::ORD_GT;
                        state_next  = ST_DONE;
                    end
                    else if (stat.j_lt_q)
                    begin
                        result_next = vsc_pkg::ORD_LT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // both at segment end; held characters are the next ones
                        state_next = ST_TOP;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            isnum_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            isnum_reg <= isnum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = result_reg;

endmodule

[hdl/version_string_compare_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_compare_unit: segment-wise version string comparator
// Loads two version strings a byte at a time and orders them on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): func 0 appends char_code to the
//   first string, func 1 to the second, func 2 compares and clears both;
//   func 3 is dropped. Bytes beyond 64 per string are dropped and flagged.
//   Output channel (out_valid / out_stall): one beat per compare, order
//   (1 first newer, 0 same, -1 second newer) and overflow.
//   Throughput: load beats are taken back to back while no compare is busy.
//   A compare holds in_stall high while it walks the buffers: each buffer
//   read is followed by a decision on the characters it fetched, other
//   decisions work on characters already held, and a last state hands off
//   the result to the output register.
//   Stall: the result sits in an output register; loads keep flowing while
//   it waits, and a following compare holds in its last state until the
//   register frees up.
//   Reset: lengths and the overflow flag clear, no beat is pending; buffer
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module version_string_compare_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [vsc_pkg::CHAR_W-1:0]  char_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [1:0]           order,
    output logic                        overflow
);

    vsc_pkg::cmd_t     cmd;
    vsc_pkg::stat_t    stat;
    logic              busy;
    logic              done;
    logic              out_free;
    logic signed [1:0] result;

    logic              out_valid_reg, out_valid_next;
    logic signed [1:0] order_reg;
    logic              overflow_reg;

    vsc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .stat     (stat),
        .out_free (out_free),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cmd      (cmd)
    );

    vsc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_code (char_code),
        .stat      (stat)
    );

    // Hold new beats while a compare is in flight
    assign in_stall = busy;

    // The output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done && out_free)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Capture the result and the overflow flag before the buffers clear
    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            order_reg    <= result;
            overflow_reg <= stat.trunc;
        end
    end

    assign out_valid = out_valid_reg;
    assign order     = order_reg;
    assign overflow  = overflow_reg;

endmodule

[dv/version_string_compare_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_compare_unit_test: self-checking bench of the version comparator
// Streams pairs of version strings into the unit a byte per beat, followed by
// a compare beat. A local predictor keeps both string buffers and works out
// the ordering and the truncation flag of every compare. Each result beat is
// checked against the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module version_string_compare_unit_test;

    import vsc_pkg::*;

    // The unit drops this code; the package has no name for it
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEM_TARGET     = 1850;
    localparam int SETTLE_CYCLES   = 400;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t str_t[$];

    // One input beat; drain asks the sender to hold it back until every
    // outstanding compare result has come back
    typedef struct packed {
        logic [1:0] fn;
        char_t      ch;
        logic       drain;
    } beat_t;

    typedef struct {
        logic signed [1:0] rank;
        logic              lost;
    } verdict_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    // Separators: '.', '-', '_', '~', '+', ' '
    localparam char_t SEP_SET[6] = '{8'h2E, 8'h2D, 8'h5F, 8'h7E, 8'h2B, 8'h20};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        func      = FUNC_LOAD1;
    char_t             char_code = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [1:0] order;
    logic              overflow;

    // Predictor state: both buffers, their fill levels and the lost-byte flag
    char_t    first_buf [MAX_LEN];
    char_t    second_buf[MAX_LEN];
    int       first_len  = 0;
    int       second_len = 0;
    logic     lost_bytes = 1'b0;

    beat_t    queued_beats[$];
    verdict_t awaited_orders[$];

    int       item_count   = 0;
    int       fail_count   = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;
    logic     beat_taken   = 1'b0;

    // Sender burst shaping
    int       burst_left = 1;
    int       gap_left   = 0;

    // Receiver stall shaping
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          hold_at    = 20;

    version_string_compare_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .order     (order),
        .overflow  (overflow)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Bytes past the fill level read as a string terminator
    function automatic char_t first_at(input int idx);
        return (idx < first_len) ? first_buf[idx] : CH_NUL;
    endfunction

    function automatic char_t second_at(input int idx);
        return (idx < second_len) ? second_buf[idx] : CH_NUL;
    endfunction

    function automatic logic is_num_char(input char_t c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_letter_char(input char_t c);
        return c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    endfunction

    function automatic logic is_word_char(input char_t c);
        return is_num_char(c) || is_letter_char(c);
    endfunction

    // Segment-wise ordering of the two buffered strings
    function automatic logic signed [1:0] rank_versions();
        int i, j, p, q, k, a, b;
        logic numeric;
        i = 0;
        j = 0;
        p = 0;
        q = 0;
        k = 0;
        // Identical strings, up to the first terminator, are equal
        forever begin
            if (first_at(k) != second_at(k))
                break;
            if (first_at(k) == CH_NUL)
                return ORD_EQ;
            k++;
        end
        while (first_at(i) != CH_NUL && second_at(j) != CH_NUL) begin
            // Skip separator runs; the longer run wins outright
            while (first_at(i) != CH_NUL && !is_word_char(first_at(i)))
                i++;
            while (second_at(j) != CH_NUL && !is_word_char(second_at(j)))
                j++;
            if (first_at(i) == CH_NUL || second_at(j) == CH_NUL)
                break;
            if ((i - p) != (j - q))
                return ((i - p) < (j - q)) ? ORD_LT : ORD_GT;
            // Segment type follows the first string
            p = i;
            q = j;
            if (is_num_char(first_at(p))) begin
                while (is_num_char(first_at(p)))
                    p++;
                while (is_num_char(second_at(q)))
                    q++;
                numeric = 1'b1;
            end
            else begin
                while (is_letter_char(first_at(p)))
                    p++;
                while (is_letter_char(second_at(q)))
                    q++;
                numeric = 1'b0;
            end
            if (q == j)
                return numeric ? ORD_GT : ORD_LT;
            // Numbers: strip leading zeros, then the longer one is larger
            if (numeric) begin
                while (i < p && first_at(i) == CH_ZERO)
                    i++;
                while (j < q && second_at(j) == CH_ZERO)
                    j++;
                if ((p - i) > (q - j))
                    return ORD_GT;
                if ((q - j) > (p - i))
                    return ORD_LT;
            end
            a = i;
            b = j;
            while (a < p && b < q) begin
                if (first_at(a) != second_at(b))
                    return (first_at(a) < second_at(b)) ? ORD_LT : ORD_GT;
                a++;
                b++;
            end
            if (a < p)
                return ORD_GT;
            if (b < q)
                return ORD_LT;
            i = p;
            j = q;
        end
        // Tail: a trailing letter segment makes a string older
        if (first_at(i) == CH_NUL && second_at(j) == CH_NUL)
            return ORD_EQ;
        if ((first_at(i) == CH_NUL && !is_letter_char(second_at(j)))
            || is_letter_char(first_at(i)))
            return ORD_LT;
        return ORD_GT;
    endfunction

    // Advance the predictor by one accepted input beat
    function automatic void apply_beat(input logic [1:0] fn, input char_t ch);
        case (fn)
            FUNC_LOAD1:
                if (first_len < MAX_LEN) begin
                    first_buf[first_len] = ch;
                    first_len++;
                end
                else
                    lost_bytes = 1'b1;
            FUNC_LOAD2:
                if (second_len < MAX_LEN) begin
                    second_buf[second_len] = ch;
                    second_len++;
                end
                else
                    lost_bytes = 1'b1;
            FUNC_CMP: begin
                awaited_orders.push_back('{rank: rank_versions(), lost: lost_bytes});
                first_len  = 0;
                second_len = 0;
                lost_bytes = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    function automatic void push_beat(input logic [1:0] fn, input char_t ch,
                                      input logic drain);
        queued_beats.push_back('{fn: fn, ch: ch, drain: drain});
        if (fn != FUNC_NOP)
            item_count++;
    endfunction

    // Interleave the bytes of both strings at random, then compare
    function automatic void load_pair(input str_t s1, input str_t s2, input logic drain);
        int a, b;
        a = 0;
        b = 0;
        while (a < s1.size() || b < s2.size()) begin
            if (b >= s2.size() || (a < s1.size() && $urandom_range(0, 1))) begin
                push_beat(FUNC_LOAD1, s1[a], 1'b0);
                a++;
            end
            else begin
                push_beat(FUNC_LOAD2, s2[b], 1'b0);
                b++;
            end
            if ($urandom_range(0, 40) == 0)
                push_beat(FUNC_NOP, char_t'($urandom_range(0, 255)), 1'b0);
        end
        push_beat(FUNC_CMP, char_t'($urandom_range(0, 255)), drain);
    endfunction

    function automatic str_t bytes_of(input string txt);
        str_t s;
        for (int k = 0; k < txt.len(); k++)
            s.push_back(txt[k]);
        return s;
    endfunction

    function automatic char_t sep_char();
        case ($urandom_range(0, 3))
            0:       return char_t'($urandom_range(128, 255));
            1:       return char_t'($urandom_range(8'h21, 8'h2F));
            default: return SEP_SET[$urandom_range(0, 5)];
        endcase
    endfunction

    // Small alphabets so that equal segments come up often
    function automatic char_t letter_char();
        if ($urandom_range(0, 4) == 0)
            return char_t'(CH_UA + $urandom_range(0, 25));
        return char_t'(CH_LA + $urandom_range(0, 3));
    endfunction

    function automatic char_t any_class_char();
        case ($urandom_range(0, 2))
            0:       return char_t'(CH_ZERO + $urandom_range(0, 9));
            1:       return letter_char();
            default: return sep_char();
        endcase
    endfunction

    // Well-formed version: digit or letter segments between separator runs
    function automatic str_t make_version();
        str_t s;
        int segs;
        segs = $urandom_range(1, 4);
        for (int k = 0; k < segs; k++) begin
            if (k > 0 || $urandom_range(0, 7) == 0)
                repeat (($urandom_range(0, 5) == 0) ? 2 : 1)
                    s.push_back(sep_char());
            if ($urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2))
                        s.push_back(CH_ZERO);
                repeat ($urandom_range(1, 3))
                    s.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
            end
            else
                repeat ($urandom_range(1, 3))
                    s.push_back(letter_char());
        end
        return s;
    endfunction

    // A near copy, so that the walk gets past the first segments
    function automatic str_t twin_of(input str_t s);
        str_t t;
        t = s;
        case ($urandom_range(0, 4))
            0: ;
            1:
                if (t.size() > 0)
                    t[$urandom_range(0, t.size() - 1)] = any_class_char();
            2: begin
                t.push_back(sep_char());
                t = {t, make_version()};
            end
            3:
                if (t.size() > 1)
                    t = t[0:$urandom_range(0, t.size() - 2)];
            default:
                t.insert($urandom_range(0, t.size()),
                         ($urandom_range(0, 1) != 0) ? CH_ZERO : sep_char());
        endcase
        return t;
    endfunction

    // Raw bytes of any value, the terminator among them
    function automatic str_t noise_string();
        str_t s;
        repeat ($urandom_range(0, 8))
            s.push_back(($urandom_range(0, 9) == 0) ? CH_NUL
                                                     : char_t'($urandom_range(0, 255)));
        return s;
    endfunction

    // Grow a string to around the buffer size, often past it
    function automatic str_t stretched(input str_t s);
        int goal;
        goal = $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
        while (s.size() < goal) begin
            s.push_back(sep_char());
            s = {s, make_version()};
        end
        return s;
    endfunction

    function automatic void build_stimulus();
        str_t none, s1, s2, tmp;
        int pair_count, kind;
        // Directed: two empty strings, the dropped code, alpha against
        // numeric, numeric by length, a terminator hiding later bytes and
        // a separator above 127, leading zeros
        load_pair(none, none, 1'b0);
        push_beat(FUNC_NOP, 8'hFF, 1'b0);
        load_pair(bytes_of("a"), bytes_of("1"), 1'b0);
        load_pair(bytes_of("1.2"), bytes_of("1.10"), 1'b0);
        load_pair('{CH_NUL, CH_NINE}, '{8'hFF}, 1'b0);
        load_pair(bytes_of("007a"), bytes_of("7b"), 1'b0);

        pair_count = 0;
        while (item_count < ITEM_TARGET) begin
            pair_count++;
            kind = $urandom_range(0, 19);
            s1 = make_version();
            if (kind < 12)
                s2 = twin_of(s1);
            else if (kind < 16)
                s2 = make_version();
            else begin
                s1 = noise_string();
                s2 = (kind == 19) ? noise_string() : twin_of(s1);
            end
            // A few long strings to fill and overrun the buffers
            if (pair_count % 25 == 5 || $urandom_range(0, 39) == 0) begin
                s1 = stretched(s1);
                case ($urandom_range(0, 2))
                    0:       ;
                    1:       s2 = twin_of(s1);
                    default: s2 = stretched(s2);
                endcase
            end
            if ($urandom_range(0, 1)) begin
                tmp = s1;
                s1  = s2;
                s2  = tmp;
            end
            load_pair(s1, s2, (pair_count % 37) == 0);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking and prediction at the rising edge
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t, result beat %0d: %s", $time, results_seen, what);
        fail_count++;
    endtask

    always @(posedge clk) begin : result_check
        verdict_t want;
        if (!rst_n)
            beat_taken <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (awaited_orders.size() == 0)
                    report_mismatch($sformatf("unexpected beat, order %0d overflow %0b",
                                              order, overflow));
                else begin
                    want = awaited_orders.pop_front();
                    if (order !== want.rank)
                        report_mismatch($sformatf("order %0d, expected %0d",
                                                  order, want.rank));
                    if (overflow !== want.lost)
                        report_mismatch($sformatf("overflow %0b, expected %0b",
                                                  overflow, want.lost));
                end
            end
            // Tell the driver whether the current input beat went through
            beat_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                apply_beat(func, char_code);
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of beats with random gaps, driven at the falling edge
    // ------------------------------------------------------------------------

    always @(negedge clk) begin : sender
        beat_t head;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (queued_beats.size() == 0)
                in_valid <= 1'b0;
            else if (queued_beats[0].drain && awaited_orders.size() != 0)
                // Hold back until every outstanding result has come back
                in_valid <= 1'b0;
            else begin
                head = queued_beats.pop_front();
                func      <= head.fn;
                char_code <= head.ch;
                in_valid  <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(4, 15)
                                                              : $urandom_range(0, 2);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern that changes mode now and then, plus long
    // hold-offs that let the unit back up into its input
    // ------------------------------------------------------------------------

    always @(negedge clk) begin : receiver
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (results_seen >= hold_at) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            hold_at   <= hold_at + 60;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(100, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= (cycle_count % 5) < 2;
                default:        out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------

    initial begin
        build_stimulus();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain the stimulus, then every outstanding result
        while (queued_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_orders.size() != 0)
            @(posedge clk);
        // Leave room for any stray result beat to show up
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[version_string_compare_unit.f]
hdl/vsc_pkg.sv
hdl/vsc_dp.sv
hdl/vsc_ctrl.sv
hdl/version_string_compare_unit.sv
dv/version_string_compare_unit_test.sv
